/* design/s2lab_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2lab_pkg: shared constants and a function for the sRGB to CIELAB converter
// Holds the matrix coefficients, the constants of the lightness function and
// the gamma decoding table generator used at elaboration.
// ----------------------------------------------------------------------------
package s2lab_pkg;

	// Default number of fraction bits of the linear-light values.
	localparam int LINEAR_BITS_DEF = 16;

	// The matrix coefficients are Q0.20 fractions.
	localparam int MAT_BITS = 20;
	localparam logic [MAT_BITS-1:0] MAT_HALF = MAT_BITS'(1 << (MAT_BITS - 1));

	// sRGB to XYZ matrix with the D65 white folded in, each row summing to 1.0.
	localparam logic [MAT_BITS-1:0] MAT [3][3] = '{
		'{20'd455029, 20'd394485, 20'd199062},
		'{20'd223004, 20'd749891, 20'd75681},
		'{20'd18619,  20'd114785, 20'd915172}
	};

	// Knee of f(t): t * 1000000 compared against 8856 in the same scale.
	localparam logic [19:0] KNEE_SCALE = 20'd1000000;
	localparam logic [13:0] KNEE_LIMIT = 14'd8856;

	// Linear branch: (903292 t + 16000 * 2^LB + 58000) / 116000.
	localparam logic [19:0] LIN_SLOPE   = 20'd903292;
	localparam logic [13:0] LIN_OFFSET  = 14'd16000;
	localparam logic [15:0] LIN_ROUND   = 16'd58000;
	localparam logic [16:0] LIN_DIVISOR = 17'd116000;

	// Gamma decoding of one 8-bit code into an unsigned fraction with lb bits.
	function automatic longint gamma_entry(int c, int lb);
		real x;
		real y;
		longint n;
		n = longint'(10 * c) <<< lb;
		x = (real'(c) / 255.0 + 0.055) / 1.055;
		y = (x ** 2.4) * (2.0 ** lb);
		if (c <= 10) begin
			return (n + 16473) / 32946;
		end
		return longint'($rtoi(y + 0.5));
	endfunction

endpackage

/* design/s2lab_froot.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2lab_froot: pipelined lightness function f(t)
// Computes the cube root of t bit by bit, one result bit per stage, and in
// parallel the linear branch by a reciprocal multiplication, then picks the
// branch by the knee comparison.
// ----------------------------------------------------------------------------
module s2lab_froot import s2lab_pkg::*; #(
	parameter int LINEAR_BITS = LINEAR_BITS_DEF
) (
	input  logic                   clk,
	input  logic [LINEAR_BITS:0]   t,
	output logic [LINEAR_BITS+1:0] f
);

	localparam int LB  = LINEAR_BITS;
	localparam int RB  = LB + 2;
	localparam int NW  = 3 * LB + 4;
	localparam int W3  = 3 * RB + 1;
	localparam int W2  = 2 * RB + 1;
	localparam int SMW = LB + 21;

	// Linear branch: the divisor is 2^DIV_SHIFT times an odd factor. The slope
	// splits into a whole part and a remainder, and the constant numerator term
	// into a quotient and a remainder, so only a small dividend is left.
	localparam int     DIV_SHIFT  = 5;
	localparam int     DIV_ODD    = int'(LIN_DIVISOR >> DIV_SHIFT);
	localparam int     SLOPE_INT  = int'(LIN_SLOPE / LIN_DIVISOR);
	localparam int     SLOPE_FRAC = int'(LIN_SLOPE % LIN_DIVISOR);
	localparam longint NUM0       = (longint'(LIN_OFFSET) << LB) + longint'(LIN_ROUND);
	localparam longint LIN_QUO    = NUM0 / longint'(LIN_DIVISOR);
	localparam longint LIN_REM    = NUM0 % longint'(LIN_DIVISOR);

	// Below the knee t < 2^(LB-6), so the reduced dividend stays below 2^XW,
	// and a reciprocal with RS = XW + 12 shift bits gives the exact quotient.
	localparam int     FW      = LB + 18;
	localparam int     XW      = LB + 5;
	localparam int     RS      = XW + 12;
	localparam int     MW      = LB + 6;
	localparam int     PRW     = XW + MW;
	localparam longint RECIP   = ((longint'(1) << RS) + longint'(DIV_ODD) - 1)
		/ longint'(DIV_ODD);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

	logic [NW-1:0] n_c;
	logic [FW-1:0] frac_c;
	logic [XW-1:0] dvd_c;
	logic [RB-1:0] base_c;
	logic          small_c;

	logic [NW-1:0]  n_s     [RB+1];
	logic [RB-1:0]  root_s  [RB+1];
	logic [W2-1:0]  sq_s    [RB+1];
	logic [W3-1:0]  cu_s    [RB+1];
	logic           small_s [RB+1];
	logic [XW-1:0]  dvd_s0;
	logic [RB-1:0]  base_s0;
	logic [PRW-1:0] prod_s1;
	logic [RB-1:0]  base_s1;
	logic [RB-1:0]  quo_s   [2:RB];
	logic [RB-1:0]  half_root;

	// Operand preparation: scaled radicand, reduced dividend, branch select.
	always_comb begin
		n_c     = NW'(t) << (2 * LB + 3);
		frac_c  = FW'(t) * FW'(SLOPE_FRAC) + FW'(LIN_REM);
		dvd_c   = XW'(frac_c >> DIV_SHIFT);
		base_c  = RB'(LIN_QUO) + RB'(t) * RB'(SLOPE_INT);
		small_c = (SMW'(t) * SMW'(KNEE_SCALE)) <= (SMW'(KNEE_LIMIT) << LB);
	end

	always_ff @(posedge clk) begin
		n_s[0]     <= n_c;
		dvd_s0     <= dvd_c;
		base_s0    <= base_c;
		root_s[0]  <= '0;
		sq_s[0]    <= '0;
		cu_s[0]    <= '0;
		small_s[0] <= small_c;
	end

	// One root bit per stage, most significant first.
	for (genvar gi = 0; gi < RB; gi++) begin : g_stage
		localparam int K = RB - 1 - gi;
		logic [W3-1:0] cand3;
		logic [W3-1:0] term1;
		logic [W3-1:0] term2;
		logic [W2-1:0] cand2;

		always_comb begin
			term1 = W3'(sq_s[gi]) << K;
			term2 = W3'(root_s[gi]) << (2 * K);
			cand3 = cu_s[gi] + (term1 << 1) + term1 + (term2 << 1) + term2
				+ (W3'(1) << (3 * K));
			cand2 = sq_s[gi] + (W2'(root_s[gi]) << (K + 1)) + (W2'(1) << (2 * K));
		end

		always_ff @(posedge clk) begin
			n_s[gi+1]     <= n_s[gi];
			small_s[gi+1] <= small_s[gi];
			if (cand3 <= W3'(n_s[gi])) begin
				root_s[gi+1] <= root_s[gi] | (RB'(1) << K);
				sq_s[gi+1]   <= cand2;
				cu_s[gi+1]   <= cand3;
			end else begin
				root_s[gi+1] <= root_s[gi];
				sq_s[gi+1]   <= sq_s[gi];
				cu_s[gi+1]   <= cu_s[gi];
			end
		end
	end

	// Reciprocal multiplication, then the quotient travels with the root.
	always_ff @(posedge clk) begin
		prod_s1  <= PRW'(dvd_s0) * PRW'(RECIP_M);
		base_s1  <= base_s0;
		quo_s[2] <= base_s1 + RB'(prod_s1 >> RS);
	end

	for (genvar gq = 2; gq < RB; gq++) begin : g_quo
		always_ff @(posedge clk) begin
			quo_s[gq+1] <= quo_s[gq];
		end
	end

	// The root of 8 t 2^(2LB) is twice the result; halve it with rounding.
	always_comb begin
		half_root = RB'(((RB + 1)'(root_s[RB]) + (RB + 1)'(1)) >> 1);
		f         = small_s[RB] ? quo_s[RB] : half_root;
	end

endmodule

/* design/srgb_to_cielab.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_cielab: 8-bit sRGB pixel to CIELAB (D65) converter
// Fully pipelined; one pixel per clock cycle.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel transfer happens at a rising edge with start high and busy low.
//   busy is always low, so a new pixel may enter in every cycle.
//   Each result appears on lightness, green_red_axis, blue_yellow_axis and
//   last_out for exactly one cycle, marked by done.
//   The latency is set by the cube root unit, which resolves one result bit
//   per pipeline stage (LINEAR_BITS + 2 stages), plus seven stages for input
//   capture, gamma lookup, matrix products, matrix sums, operand preparation,
//   output scaling and the output register.
//   Results leave in input order. The receiver cannot stall, so nothing
//   holds the pipeline; it never stops.
//   Reset clears all valid bits at once; pixels in flight are dropped and
//   the block takes a pixel in the first cycle after reset is released.
// ----------------------------------------------------------------------------
module srgb_to_cielab import s2lab_pkg::*; #(
	parameter int LINEAR_BITS = LINEAR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic               last_pixel,
	output logic               done,
	output logic [14:0]        lightness,
	output logic signed [15:0] green_red_axis,
	output logic signed [15:0] blue_yellow_axis,
	output logic               last_out
);

	localparam int LB  = LINEAR_BITS;
	localparam int LW  = LB + 1;
	localparam int RB  = LB + 2;
	localparam int PW  = LW + MAT_BITS;
	localparam int SW  = PW + 2;
	localparam int EW  = LB + 14;
	localparam int OW  = EW + 8;
	localparam int LAT = RB + 7;

	localparam logic signed [EW-1:0] C116 = EW'(116);
	localparam logic signed [EW-1:0] C500 = EW'(500);
	localparam logic signed [EW-1:0] C200 = EW'(200);
	localparam logic signed [EW-1:0] C16  = EW'(16);
	localparam logic signed [OW-1:0] HALF = OW'(1) <<< (LB - 1);
	localparam logic signed [OW-1:0] L_MAX = OW'(25600);
	localparam logic signed [OW-1:0] A_MAX = OW'(32767);
	localparam logic signed [OW-1:0] A_MIN = -OW'(32768);

	logic [LW-1:0] lin_lut [256];

	logic [7:0]    red_s1, green_s1, blue_s1;
	logic [LW-1:0] lin_s2 [3];
	logic [PW-1:0] prod_s3 [3][3];
	logic [LW-1:0] xyz_s4 [3];
	logic [RB-1:0] f_c [3];

	logic signed [EW-1:0] fxs, fys, fzs;
	logic signed [EW-1:0] l_c, a_c, b_c;
	logic signed [EW-1:0] l_s5, a_s5, b_s5;
	logic signed [OW-1:0] lq, aq, bq;
	logic [14:0]          l_sat;
	logic [15:0]          a_sat, b_sat;

	logic [14:0] lightness_s6;
	logic [15:0] a_s6, b_s6;

	logic [LAT-1:0] vld_s;
	logic [LAT-1:0] last_s;

	// Gamma decoding table, built at elaboration.
	for (genvar gi = 0; gi < 256; gi++) begin : g_lut
		assign lin_lut[gi] = LW'(gamma_entry(gi, LB));
	end

	assign busy = 1'b0;

	// Input capture and gamma lookup.
	always_ff @(posedge clk) begin
		red_s1    <= red;
		green_s1  <= green;
		blue_s1   <= blue;
		lin_s2[0] <= lin_lut[red_s1];
		lin_s2[1] <= lin_lut[green_s1];
		lin_s2[2] <= lin_lut[blue_s1];
	end

	// Matrix products, then row sums rounded to LB fraction bits.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s3[i][j] <= PW'(MAT[i][j]) * PW'(lin_s2[j]);
			end
			xyz_s4[i] <= LW'((SW'(prod_s3[i][0]) + SW'(prod_s3[i][1])
				+ SW'(prod_s3[i][2]) + SW'(MAT_HALF)) >> MAT_BITS);
		end
	end

	// Lightness function for X, Y and Z.
	for (genvar gc = 0; gc < 3; gc++) begin : g_froot
		s2lab_froot #(
			.LINEAR_BITS(LINEAR_BITS)
		) u_froot (
			.clk(clk),
			.t  (xyz_s4[gc]),
			.f  (f_c[gc])
		);
	end

	// L, a and b before scaling, still with LB fraction bits.
	always_comb begin
		fxs = signed'(EW'(f_c[0]));
		fys = signed'(EW'(f_c[1]));
		fzs = signed'(EW'(f_c[2]));
		l_c = fys * C116 - (C16 <<< LB);
		a_c = (fxs - fys) * C500;
		b_c = (fys - fzs) * C200;
	end

	always_ff @(posedge clk) begin
		l_s5 <= l_c;
		a_s5 <= a_c;
		b_s5 <= b_c;
	end

	// Rounding to Q8.8 with halves up, then saturation to the port ranges.
	always_comb begin
		lq = ((OW'(l_s5) <<< 8) + HALF) >>> LB;
		aq = ((OW'(a_s5) <<< 8) + HALF) >>> LB;
		bq = ((OW'(b_s5) <<< 8) + HALF) >>> LB;
		if (lq < 0) begin
			l_sat = '0;
		end else if (lq > L_MAX) begin
			l_sat = 15'(L_MAX);
		end else begin
			l_sat = 15'(lq);
		end
		if (aq < A_MIN) begin
			a_sat = 16'(A_MIN);
		end else if (aq > A_MAX) begin
			a_sat = 16'(A_MAX);
		end else begin
			a_sat = 16'(aq);
		end
		if (bq < A_MIN) begin
			b_sat = 16'(A_MIN);
		end else if (bq > A_MAX) begin
			b_sat = 16'(A_MAX);
		end else begin
			b_sat = 16'(bq);
		end
	end

	always_ff @(posedge clk) begin
		lightness_s6 <= l_sat;
		a_s6         <= a_sat;
		b_s6         <= b_sat;
	end

	// Valid and last-pixel bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			last_s <= '0;
		end else begin
			vld_s  <= {vld_s[LAT-2:0], start};
			last_s <= {last_s[LAT-2:0], start & last_pixel};
		end
	end

	assign done             = vld_s[LAT-1];
	assign last_out         = last_s[LAT-1];
	assign lightness        = lightness_s6;
	assign green_red_axis   = signed'(a_s6);
	assign blue_yellow_axis = signed'(b_s6);

	// Every result follows exactly one input transfer.
	a_done_follows_start : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching input transfer");

	a_start_gives_done : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("input transfer without a result");

	a_last_only_with_done : assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> done)
		else $error("last flag outside a result");

	a_lightness_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> lightness <= 15'd25600)
		else $error("lightness above 100");

endmodule
